[rtl/core/sliding_window_min_max_avg_core_macros.svh]
// Assertion macros for the sliding window statistics core.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef SLIDING_WINDOW_MIN_MAX_AVG_CORE_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_AVG_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while reset is released.
`define SWMMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked at every edge, reset included.
`define SWMMA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SWMMA_ASSERT(lbl, prop, msg)
`define SWMMA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/core/swmma_pkg.sv]
// Shared constants, types and helper functions for the sliding window core.
// No dependencies; used by every module of the block.
package swmma_pkg;

  localparam int unsigned MaxWindow     = 32;
  localparam int unsigned SampleBits    = 12;
  localparam int unsigned CfgBits       = 6;
  localparam int unsigned DefaultWindow = 8;

  localparam int unsigned SampleMax = (1 << SampleBits) - 1;
  localparam int unsigned IdxBits   = $clog2(MaxWindow);
  localparam int unsigned WinBits   = $clog2(MaxWindow + 1);
  localparam int unsigned SumBits   = $clog2(MaxWindow * SampleMax + 1);
  localparam int unsigned CntBits   = $clog2(SumBits + 1);

  // Divider status handed back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Maps a written window size onto the legal range.
  function automatic logic [WinBits-1:0] limit_window(logic [CfgBits-1:0] v);
    logic [WinBits-1:0] r;
    if (v == '0) begin
      r = WinBits'((DefaultWindow > MaxWindow) ? MaxWindow : DefaultWindow);
    end else if (int'(v) > int'(MaxWindow)) begin
      r = WinBits'(MaxWindow);
    end else begin
      r = WinBits'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/swmma_ring.sv]
// Sample history memory: one write port and one registered read port.
// Depends on swmma_pkg for depth and sample width.
module swmma_ring (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [swmma_pkg::IdxBits-1:0]    waddr_i,
  input  logic [swmma_pkg::SampleBits-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [swmma_pkg::IdxBits-1:0]    raddr_i,
  output logic [swmma_pkg::SampleBits-1:0] rdata_o
);

  logic [swmma_pkg::SampleBits-1:0] mem_q [swmma_pkg::MaxWindow];
  logic [swmma_pkg::SampleBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/swmma_div.sv]
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on swmma_pkg for operand widths and the status struct.
module swmma_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [swmma_pkg::SumBits-1:0]    dividend_i,
  input  logic [swmma_pkg::WinBits-1:0]    divisor_i,
  output swmma_pkg::div_stat_t             stat_o,
  output logic [swmma_pkg::SampleBits-1:0] quotient_o
);

  localparam int unsigned SB = swmma_pkg::SumBits;
  localparam int unsigned WB = swmma_pkg::WinBits;
  localparam int unsigned CB = swmma_pkg::CntBits;

  logic [SB-1:0] quo_q, quo_d;
  logic [WB-1:0] rem_q, rem_d;
  logic [WB-1:0] dvs_q, dvs_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [WB:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[SB-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CB'(SB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits in WB bits.
      rem_d = fits ? WB'(trial - {1'b0, dvs_q}) : trial[WB-1:0];
      quo_d = {quo_q[SB-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  // The average never exceeds the largest sample, so the low bits hold it.
  assign quotient_o  = quo_q[swmma_pkg::SampleBits-1:0];

endmodule

[rtl/core/sliding_window_min_max_avg_core.sv]
// Sliding window minimum, maximum and average over converter samples.
// Depends on swmma_pkg, swmma_ring, swmma_div and the assertion macro header.
//
// Usage: the input channel (in_valid_i / in_ready_o / sample_i) carries one
// 12-bit sample per request. Each request yields exactly one result on the
// output channel (out_valid_o / out_ready_i) with the window minimum, maximum,
// truncated average, and the overall minimum and maximum since the last clear.
// The window size register is written through cfg_we_i / cfg_wdata_i; a write
// clears the history and the overall statistics. A value of zero selects a
// window of 8 and values above 32 select 32.
// Flow: after a request is accepted the sequencer walks the filled entries,
// one memory read per cycle, then runs a bit-serial divide of the window sum
// by the fill count. The read port and the divider set the time to a result;
// one request is in flight at a time and in_ready_o is low until it finishes.
// Reset clears the window size to 8, the fill count, the write position and
// the statistics; no memory clearing pass is needed. The result sits in an
// output register, so a new request is taken while it waits; if the receiver
// stalls, the next result waits in the sequencer until the register frees up.
`include "sliding_window_min_max_avg_core_macros.svh"

module sliding_window_min_max_avg_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swmma_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [swmma_pkg::SampleBits-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [swmma_pkg::SampleBits-1:0] window_min_o,
  output logic [swmma_pkg::SampleBits-1:0] window_max_o,
  output logic [swmma_pkg::SampleBits-1:0] window_avg_o,
  output logic [swmma_pkg::SampleBits-1:0] overall_min_o,
  output logic [swmma_pkg::SampleBits-1:0] overall_max_o
);

  localparam int unsigned SW = swmma_pkg::SampleBits;
  localparam int unsigned WB = swmma_pkg::WinBits;
  localparam int unsigned IB = swmma_pkg::IdxBits;
  localparam int unsigned SB = swmma_pkg::SumBits;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDiv,
    StDone
  } state_e;

  state_e        state_q, state_d;
  logic [WB-1:0] ws_q, ws_d;
  logic [IB-1:0] wp_q, wp_d;
  logic [WB-1:0] fill_q, fill_d;
  logic [SW-1:0] seen_min_q, seen_min_d;
  logic [SW-1:0] seen_max_q, seen_max_d;
  logic [SW-1:0] min_q, min_d;
  logic [SW-1:0] max_q, max_d;
  logic [SB-1:0] sum_q, sum_d;
  logic [WB-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] omin_q, omin_d;
  logic [SW-1:0] omax_q, omax_d;
  logic [SW-1:0] oavg_q, oavg_d;
  logic [SW-1:0] ogmin_q, ogmin_d;
  logic [SW-1:0] ogmax_q, ogmax_d;

  logic                 accept;
  logic [IB-1:0]        wp_eff;
  logic [WB-1:0]        wp_inc;
  logic                 rd_issue;
  logic                 div_start;
  logic                 out_free;
  logic [SW-1:0]        rdata;
  logic [SW-1:0]        div_q;
  logic [SW-1:0]        smin_new;
  logic [SW-1:0]        smax_new;
  swmma_pkg::div_stat_t div_st;

  assign in_ready_o = (state_q == StIdle) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // A stale write position beyond the window restarts at the first entry.
  assign wp_eff = (WB'(wp_q) >= ws_q) ? '0 : wp_q;
  assign wp_inc = WB'(wp_eff) + 1'b1;

  // The walk reads entries 0 .. fill-1; data returns in the cycle after issue.
  assign rd_issue  = (state_q == StScan) && (rd_idx_q < fill_q);
  assign div_start = (state_q == StScan) && !rd_issue && !rd_pend_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign smin_new = (min_q < seen_min_q) ? min_q : seen_min_q;
  assign smax_new = (max_q > seen_max_q) ? max_q : seen_max_q;

  swmma_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_eff),
    .wdata_i (sample_i),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IB-1:0]),
    .rdata_o (rdata)
  );

  swmma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .stat_o     (div_st),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    seen_min_d  = seen_min_q;
    seen_max_d  = seen_max_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q;
    omin_d      = omin_q;
    omax_d      = omax_q;
    oavg_d      = oavg_q;
    ogmin_d     = ogmin_q;
    ogmax_d     = ogmax_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          wp_d     = (wp_inc >= ws_q) ? '0 : wp_inc[IB-1:0];
          fill_d   = (fill_q < ws_q) ? fill_q + 1'b1 : fill_q;
          min_d    = SW'(swmma_pkg::SampleMax);
          max_d    = '0;
          sum_d    = '0;
          rd_idx_d = '0;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        rd_pend_d = rd_issue;
        if (rd_pend_q) begin
          if (rdata < min_q) begin
            min_d = rdata;
          end
          if (rdata > max_q) begin
            max_d = rdata;
          end
          sum_d = sum_q + SB'(rdata);
        end
        if (div_start) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_st.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          seen_min_d  = smin_new;
          seen_max_d  = smax_new;
          omin_d      = min_q;
          omax_d      = max_q;
          oavg_d      = div_q;
          ogmin_d     = smin_new;
          ogmax_d     = smax_new;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A window size write restarts the history and the overall statistics.
    if (cfg_we_i) begin
      ws_d       = swmma_pkg::limit_window(cfg_wdata_i);
      wp_d       = '0;
      fill_d     = '0;
      seen_min_d = SW'(swmma_pkg::SampleMax);
      seen_max_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ws_q        <= swmma_pkg::limit_window(
                       swmma_pkg::CfgBits'(swmma_pkg::DefaultWindow));
      wp_q        <= '0;
      fill_q      <= '0;
      seen_min_q  <= SW'(swmma_pkg::SampleMax);
      seen_max_q  <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      omin_q      <= '0;
      omax_q      <= '0;
      oavg_q      <= '0;
      ogmin_q     <= '0;
      ogmax_q     <= '0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      seen_min_q  <= seen_min_d;
      seen_max_q  <= seen_max_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      omin_q      <= omin_d;
      omax_q      <= omax_d;
      oavg_q      <= oavg_d;
      ogmin_q     <= ogmin_d;
      ogmax_q     <= ogmax_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_min_o  = omin_q;
  assign window_max_o  = omax_q;
  assign window_avg_o  = oavg_q;
  assign overall_min_o = ogmin_q;
  assign overall_max_o = ogmax_q;

  // The fill count never runs past the configured window.
  `SWMMA_ASSERT(a_fill_in_window, fill_q <= ws_q, "fill count exceeds window size")
  // The divider is idle whenever a new request can be taken.
  `SWMMA_ASSERT(a_ready_div_idle, in_ready_o |-> !div_st.busy, "request taken while dividing")
  // A finished average lies between the window extremes.
  `SWMMA_ASSERT(a_avg_bounded,
    (state_q == StDone) |-> (min_q <= max_q && div_q >= min_q && div_q <= max_q),
    "window average outside window extremes")
  // A window size write leaves an empty history behind it.
  `SWMMA_ASSERT(a_cfg_clears, cfg_we_i |=> (fill_q == '0 && wp_q == '0),
    "window size write did not clear history")
  // Once reset has been seen at an edge, no result is presented at the next one.
  `SWMMA_ASSERT_RST(a_rst_no_out, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule
